// File: src/gadd_pkg.sv
// gadd_pkg: shared types, microcode codes and calendar functions for the
// gregorian date add unit. No dependencies.
`timescale 1ns / 1ps

package gadd_pkg;

    localparam int STEP_W = 3;
    localparam int OP_W   = 3;
    localparam int COND_W = 3;

    localparam int DAY_W  = 5;
    localparam int MON_W  = 4;
    localparam int YEAR_W = 14;
    localparam int ADD_W  = 15;
    localparam int YACC_W = YEAR_W + 1;
    localparam int REM_W  = 16;
    localparam int Y400_W = 9;

    localparam logic [MON_W-1:0]  MONTHS_PER_YEAR = 4'd12;
    localparam logic [YACC_W-1:0] CYCLE_400       = 15'd400;
    localparam logic [Y400_W-1:0] CYCLE_400_LAST  = 9'd399;

    // microcode step addresses
    localparam logic [STEP_W-1:0] STEP_IDLE = 3'd0;
    localparam logic [STEP_W-1:0] STEP_MOD  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_CHK  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_DOY  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_ADD  = 3'd4;
    localparam logic [STEP_W-1:0] STEP_WALK = 3'd5;
    localparam logic [STEP_W-1:0] STEP_EMIT = 3'd6;
    localparam logic [STEP_W-1:0] STEP_BAD  = 3'd7;

    // datapath operations
    localparam logic [OP_W-1:0] OP_LOAD = 3'd0;
    localparam logic [OP_W-1:0] OP_MOD  = 3'd1;
    localparam logic [OP_W-1:0] OP_INIT = 3'd2;
    localparam logic [OP_W-1:0] OP_DOY  = 3'd3;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd4;
    localparam logic [OP_W-1:0] OP_WALK = 3'd5;
    localparam logic [OP_W-1:0] OP_EMIT = 3'd6;
    localparam logic [OP_W-1:0] OP_BAD  = 3'd7;

    // jump conditions
    localparam logic [COND_W-1:0] COND_NEVER   = 3'd0;
    localparam logic [COND_W-1:0] COND_ALWAYS  = 3'd1;
    localparam logic [COND_W-1:0] COND_NOSTART = 3'd2;
    localparam logic [COND_W-1:0] COND_GE400   = 3'd3;
    localparam logic [COND_W-1:0] COND_INVALID = 3'd4;
    localparam logic [COND_W-1:0] COND_LT_SMON = 3'd5;
    localparam logic [COND_W-1:0] COND_GT_LEN  = 3'd6;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] target;
    } ctrl_word_t;

    typedef struct packed {
        logic ge400;
        logic invalid;
        logic lt_smon;
        logic gt_len;
    } dp_flags_t;

    function automatic logic is_leap(input logic [Y400_W-1:0] y);
        logic cent;
        cent = (y == 9'd0) || (y == 9'd100) || (y == 9'd200) || (y == 9'd300);
        return ((y[1:0] == 2'd0) && !cent) || (y == 9'd0);
    endfunction

    function automatic logic [DAY_W-1:0] days_of(input logic [Y400_W-1:0] y,
                                                 input logic [MON_W-1:0] m);
        logic [DAY_W-1:0] n;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     n = 5'd30;
            4'd2:                                        n = is_leap(y) ? 5'd29 : 5'd28;
            default:                                     n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

// File: src/gadd_rom.sv
// gadd_rom: microcode program store, one control word per step address.
// Depends on gadd_pkg.
`timescale 1ns / 1ps

module gadd_rom
    import gadd_pkg::*;
(
    input  logic [STEP_W-1:0] step,
    output ctrl_word_t        ctrl
);

    always_comb
    begin
        unique case (step)
            STEP_IDLE: ctrl = '{op: OP_LOAD, cond: COND_NOSTART, target: STEP_IDLE};
            STEP_MOD:  ctrl = '{op: OP_MOD,  cond: COND_GE400,   target: STEP_MOD};
            STEP_CHK:  ctrl = '{op: OP_INIT, cond: COND_INVALID, target: STEP_BAD};
            STEP_DOY:  ctrl = '{op: OP_DOY,  cond: COND_LT_SMON, target: STEP_DOY};
            STEP_ADD:  ctrl = '{op: OP_ADD,  cond: COND_NEVER,   target: STEP_IDLE};
            STEP_WALK: ctrl = '{op: OP_WALK, cond: COND_GT_LEN,  target: STEP_WALK};
            STEP_EMIT: ctrl = '{op: OP_EMIT, cond: COND_ALWAYS,  target: STEP_IDLE};
            STEP_BAD:  ctrl = '{op: OP_BAD,  cond: COND_ALWAYS,  target: STEP_IDLE};
        endcase
    end

endmodule

// File: src/gadd_seq.sv
// gadd_seq: step counter with conditional jumps driven by the microcode word.
// Depends on gadd_pkg.
`timescale 1ns / 1ps

module gadd_seq
    import gadd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ctrl_word_t        ctrl,
    input  dp_flags_t         flags,
    output logic [STEP_W-1:0] step,
    output logic              busy
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              jump;

    always_comb
    begin
        unique case (ctrl.cond)
            COND_ALWAYS:  jump = 1'b1;
            COND_NOSTART: jump = !start;
            COND_GE400:   jump = flags.ge400;
            COND_INVALID: jump = flags.invalid;
            COND_LT_SMON: jump = flags.lt_smon;
            COND_GT_LEN:  jump = flags.gt_len;
            default:      jump = 1'b0;
        endcase
        step_next = jump ? ctrl.target : step_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign step = step_reg;
    assign busy = (step_reg != STEP_IDLE);

endmodule

// File: src/gadd_datapath.sv
// gadd_datapath: date registers, month-length logic and result registers,
// steered by the microcode operation. Depends on gadd_pkg.
`timescale 1ns / 1ps

module gadd_datapath
    import gadd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [OP_W-1:0]   op,
    input  logic [DAY_W-1:0]  start_day,
    input  logic [MON_W-1:0]  start_month,
    input  logic [YEAR_W-1:0] start_year,
    input  logic [ADD_W-1:0]  days_to_add,
    output dp_flags_t         flags,
    output logic              done,
    output logic [DAY_W-1:0]  new_day,
    output logic [MON_W-1:0]  new_month,
    output logic [YEAR_W-1:0] new_year,
    output logic              date_valid
);

    logic [DAY_W-1:0]  day_reg,  day_next;
    logic [MON_W-1:0]  smon_reg, smon_next;
    logic [ADD_W-1:0]  add_reg,  add_next;
    logic [YACC_W-1:0] year_reg, year_next;
    logic [YACC_W-1:0] y400_reg, y400_next;
    logic [REM_W-1:0]  rem_reg,  rem_next;
    logic [MON_W-1:0]  cur_reg,  cur_next;

    logic [DAY_W-1:0]  res_day_reg,  res_day_next;
    logic [MON_W-1:0]  res_mon_reg,  res_mon_next;
    logic [YEAR_W-1:0] res_year_reg, res_year_next;
    logic              done_reg,  done_next;
    logic              valid_reg, valid_next;

    logic [Y400_W-1:0] y400_lo;
    logic [DAY_W-1:0]  len_cur;
    logic [DAY_W-1:0]  len_smon;
    logic              mon_ok;

    assign y400_lo  = y400_reg[Y400_W-1:0];
    assign len_cur  = days_of(y400_lo, cur_reg);
    assign len_smon = days_of(y400_lo, smon_reg);
    assign mon_ok   = (smon_reg != 4'd0) && (smon_reg <= MONTHS_PER_YEAR);

    assign flags.ge400   = (y400_reg >= CYCLE_400);
    assign flags.invalid = !mon_ok || (day_reg == 5'd0) || (day_reg > len_smon);
    assign flags.lt_smon = (cur_reg < smon_reg);
    assign flags.gt_len  = (rem_reg > {11'd0, len_cur});

    always_comb
    begin
        day_next      = day_reg;
        smon_next     = smon_reg;
        add_next      = add_reg;
        year_next     = year_reg;
        y400_next     = y400_reg;
        rem_next      = rem_reg;
        cur_next      = cur_reg;
        res_day_next  = res_day_reg;
        res_mon_next  = res_mon_reg;
        res_year_next = res_year_reg;
        valid_next    = valid_reg;
        done_next     = 1'b0;
        unique case (op)
            OP_LOAD:
            begin
                day_next  = start_day;
                smon_next = start_month;
                add_next  = days_to_add;
                year_next = {1'b0, start_year};
                y400_next = {1'b0, start_year};
            end
            OP_MOD:
            begin
                if (flags.ge400)
                begin
                    y400_next = y400_reg - CYCLE_400;
                end
            end
            OP_INIT:
            begin
                rem_next = {11'd0, day_reg};
                cur_next = 4'd1;
            end
            OP_DOY:
            begin
                if (flags.lt_smon)
                begin
                    rem_next = rem_reg + {11'd0, len_cur};
                    cur_next = cur_reg + 4'd1;
                end
            end
            OP_ADD:
            begin
                rem_next = rem_reg + {1'b0, add_reg};
                cur_next = 4'd1;
            end
            OP_WALK:
            begin
                if (flags.gt_len)
                begin
                    rem_next = rem_reg - {11'd0, len_cur};
                    if (cur_reg == MONTHS_PER_YEAR)
                    begin
                        cur_next  = 4'd1;
                        year_next = year_reg + 15'd1;
                        y400_next = (y400_lo == CYCLE_400_LAST) ? 15'd0 : y400_reg + 15'd1;
                    end
                    else
                    begin
                        cur_next = cur_reg + 4'd1;
                    end
                end
            end
            OP_EMIT:
            begin
                res_day_next  = rem_reg[DAY_W-1:0];
                res_mon_next  = cur_reg;
                res_year_next = year_reg[YEAR_W-1:0];
                valid_next    = 1'b1;
                done_next     = 1'b1;
            end
            OP_BAD:
            begin
                res_day_next  = '0;
                res_mon_next  = '0;
                res_year_next = '0;
                valid_next    = 1'b0;
                done_next     = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        day_reg      <= day_next;
        smon_reg     <= smon_next;
        add_reg      <= add_next;
        year_reg     <= year_next;
        y400_reg     <= y400_next;
        rem_reg      <= rem_next;
        cur_reg      <= cur_next;
        res_day_reg  <= res_day_next;
        res_mon_reg  <= res_mon_next;
        res_year_reg <= res_year_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            done_reg  <= done_next;
            valid_reg <= valid_next;
        end
    end

    assign done       = done_reg;
    assign new_day    = res_day_reg;
    assign new_month  = res_mon_reg;
    assign new_year   = res_year_reg;
    assign date_valid = valid_reg;

endmodule

// File: src/gregorian_add_days_to_date_unit.sv
// gregorian_add_days_to_date_unit: top level of the date add unit.
// Depends on gadd_pkg, gadd_rom, gadd_seq and gadd_datapath.
`timescale 1ns / 1ps

// Adds a day count to a Gregorian date (day, month, year).
// A transfer in happens at a rising edge with start high and busy low; the
// date fields and days_to_add are sampled at that edge. busy stays high
// until the result is out, so one item is worked on at a time.
// The result shows on new_day, new_month, new_year and date_valid for one
// cycle with done high; the receiver cannot stall it, and the fields hold
// their values until the next result.
// After the input transfer the steps run in order: year mod 400 reduction,
// the date check, the sum of the months before the start month, the add of
// days_to_add, the month walk and the result write.
// The month walk goes one month per cycle through the remainder subtractor.
// An invalid date (month outside 1 to 12, day 0 or past month end) leaves
// the date check and returns all zeros with date_valid low. A new start is
// taken in the cycle done is high.
// Reset clears the step counter, done and date_valid; the unit is idle after.

module gregorian_add_days_to_date_unit
    import gadd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [DAY_W-1:0]  start_day,
    input  logic [MON_W-1:0]  start_month,
    input  logic [YEAR_W-1:0] start_year,
    input  logic [ADD_W-1:0]  days_to_add,
    output logic              done,
    output logic [DAY_W-1:0]  new_day,
    output logic [MON_W-1:0]  new_month,
    output logic [YEAR_W-1:0] new_year,
    output logic              date_valid
);

    logic [STEP_W-1:0] step;
    ctrl_word_t        ctrl;
    dp_flags_t         flags;

    gadd_rom u_rom (
        .step (step),
        .ctrl (ctrl)
    );

    gadd_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .ctrl  (ctrl),
        .flags (flags),
        .step  (step),
        .busy  (busy)
    );

    gadd_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (ctrl.op),
        .start_day   (start_day),
        .start_month (start_month),
        .start_year  (start_year),
        .days_to_add (days_to_add),
        .flags       (flags),
        .done        (done),
        .new_day     (new_day),
        .new_month   (new_month),
        .new_year    (new_year),
        .date_valid  (date_valid)
    );

endmodule

// File: src/gadd_checker.sv
// gadd_checker: port-level checks for the date add unit, bound to the top.
// Depends on gadd_pkg and gregorian_add_days_to_date_unit.
`timescale 1ns / 1ps

module gadd_checker
    import gadd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic [DAY_W-1:0]  new_day,
    input logic [MON_W-1:0]  new_month,
    input logic [YEAR_W-1:0] new_year,
    input logic              date_valid
);

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("not busy after input transfer");

    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe on two cycles in a row");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !date_valid) |-> (new_day == '0 && new_month == '0 && new_year == '0))
        else $error("invalid result not zeroed");

    a_good_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && date_valid) |-> (new_day != '0 && new_month != '0
                                  && new_month <= MONTHS_PER_YEAR))
        else $error("valid result out of range");

endmodule

bind gregorian_add_days_to_date_unit gadd_checker u_gadd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .new_day    (new_day),
    .new_month  (new_month),
    .new_year   (new_year),
    .date_valid (date_valid)
);

// File: dv/tb_gregorian_add_days_to_date_unit.sv
// tb_gregorian_add_days_to_date_unit: self-checking bench for the date add unit.
// Drives directed and random dates through start/busy and checks every done strobe
// against a built-in calendar predictor. Depends on gadd_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_gregorian_add_days_to_date_unit;
    import gadd_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int RANDOM_ITEMS = 400;
    localparam int DRAIN_CYCLES = 1300;

    typedef struct packed {
        logic [DAY_W-1:0]  day;
        logic [MON_W-1:0]  month;
        logic [YEAR_W-1:0] year;
        logic              valid;
    } sum_date_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [DAY_W-1:0]  start_day;
    logic [MON_W-1:0]  start_month;
    logic [YEAR_W-1:0] start_year;
    logic [ADD_W-1:0]  days_to_add;
    logic              done;
    logic [DAY_W-1:0]  new_day;
    logic [MON_W-1:0]  new_month;
    logic [YEAR_W-1:0] new_year;
    logic              date_valid;

    int unsigned cycle_count;
    bit          calm;

    function automatic bit year_is_leap(input int unsigned yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    function automatic int unsigned month_days(input int unsigned yr, input int unsigned mon);
        int unsigned n;
        case (mon)
            2:          n = year_is_leap(yr) ? 29 : 28;
            4, 6, 9, 11: n = 30;
            default:    n = 31;
        endcase
        return n;
    endfunction

    function automatic sum_date_t add_days_to_date(input logic [DAY_W-1:0] d,
                                                   input logic [MON_W-1:0] m,
                                                   input logic [YEAR_W-1:0] y,
                                                   input logic [ADD_W-1:0] add);
        sum_date_t   r;
        int unsigned yr;
        int unsigned mon;
        int unsigned rem;
        r = '0;
        yr = 32'(y);
        if (m < 1 || m > MONTHS_PER_YEAR || d == 0 || d > month_days(yr, 32'(m)))
            return r;
        rem = 32'(d);
        for (mon = 1; mon < 32'(m); mon++)
            rem += month_days(yr, mon);
        rem += 32'(add);
        mon = 1;
        while (rem > month_days(yr, mon))
        begin
            rem -= month_days(yr, mon);
            mon++;
            if (mon > MONTHS_PER_YEAR)
            begin
                mon = 1;
                yr++;
            end
        end
        r.day   = rem[DAY_W-1:0];
        r.month = mon[MON_W-1:0];
        r.year  = yr[YEAR_W-1:0];
        r.valid = 1'b1;
        return r;
    endfunction

    class date_scoreboard;
        sum_date_t   expected_q[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned valid_seen;
        int unsigned invalid_seen;

        function new();
            mismatches   = 0;
            checked      = 0;
            valid_seen   = 0;
            invalid_seen = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void note_input(input logic [DAY_W-1:0] d, input logic [MON_W-1:0] m,
                                 input logic [YEAR_W-1:0] y, input logic [ADD_W-1:0] add);
            expected_q.push_back(add_days_to_date(d, m, y, add));
        endfunction

        task log_mismatch(input string what, input int unsigned got, input int unsigned want);
            $display("mismatch at cycle %0d: %s got %0d expected %0d",
                     cycle_count, what, got, want);
            mismatches++;
        endtask

        task check_result(input sum_date_t got);
            sum_date_t want;
            if (expected_q.size() == 0)
            begin
                log_mismatch("unexpected result, day", 32'(got.day), 32'd0);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (want.valid)
                valid_seen++;
            else
                invalid_seen++;
            if (got.day !== want.day)
                log_mismatch("new_day", 32'(got.day), 32'(want.day));
            if (got.month !== want.month)
                log_mismatch("new_month", 32'(got.month), 32'(want.month));
            if (got.year !== want.year)
                log_mismatch("new_year", 32'(got.year), 32'(want.year));
            if (got.valid !== want.valid)
                log_mismatch("date_valid", 32'(got.valid), 32'(want.valid));
        endtask
    endclass

    date_scoreboard sb;

    gregorian_add_days_to_date_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .start_day   (start_day),
        .start_month (start_month),
        .start_year  (start_year),
        .days_to_add (days_to_add),
        .done        (done),
        .new_day     (new_day),
        .new_month   (new_month),
        .new_year    (new_year),
        .date_valid  (date_valid)
    );

    always
    begin
        clk = 1'b1;
        #CLK_HALF;
        clk = 1'b0;
        #CLK_HALF;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[gregorian_add_days_to_date_unit] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result({new_day, new_month, new_year, date_valid});
    end

    // one transfer; start is left high so a following call can go back to back
    task automatic send_date(input logic [DAY_W-1:0] d, input logic [MON_W-1:0] m,
                             input logic [YEAR_W-1:0] y, input logic [ADD_W-1:0] add);
        int unsigned gap;
        gap = 0;
        if (!calm && $urandom_range(99) < 33)
            gap = ($urandom_range(9) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 6);
        @(negedge clk);
        if (gap > 0)
        begin
            start = 1'b0;
            while (busy)
                @(negedge clk);
            repeat (gap) @(negedge clk);
        end
        start       = 1'b1;
        start_day   = d;
        start_month = m;
        start_year  = y;
        days_to_add = add;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_input(d, m, y, add);
    endtask

    task automatic drain_results();
        @(negedge clk);
        start = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic send_random_date();
        int unsigned      pick;
        int unsigned      len;
        logic [DAY_W-1:0]  d;
        logic [MON_W-1:0]  m;
        logic [YEAR_W-1:0] y;
        logic [ADD_W-1:0]  add;
        pick = $urandom_range(99);
        if (pick < 60)
            y = YEAR_W'($urandom_range(1, 9999));
        else if (pick < 80)
            y = YEAR_W'($urandom_range(0, 16383));
        else
            case ($urandom_range(7))
                0: y = 14'd0;
                1: y = 14'd1900;
                2: y = 14'd2000;
                3: y = 14'd2100;
                4: y = 14'd2400;
                5: y = 14'd9999;
                6: y = 14'd16383;
                default: y = YEAR_W'($urandom_range(16290, 16383));
            endcase
        pick = $urandom_range(99);
        if (pick < 45)
            add = ADD_W'($urandom_range(0, 32767));
        else if (pick < 80)
            add = ADD_W'($urandom_range(0, 400));
        else if (pick < 95)
            add = ADD_W'($urandom_range(0, 3000));
        else
            add = $urandom_range(1) ? 15'd32767 : 15'd0;
        m = MON_W'($urandom_range(1, 12));
        len = month_days(32'(y), 32'(m));
        if ($urandom_range(99) < 88)
            d = ($urandom_range(4) == 0) ? len[DAY_W-1:0] : DAY_W'($urandom_range(1, len));
        else
            case ($urandom_range(2))
                0: d = 5'd0;
                1: d = (len < 31) ? DAY_W'($urandom_range(len + 1, 31)) : 5'd0;
                default:
                begin
                    m = $urandom_range(1) ? 4'd0 : MON_W'($urandom_range(13, 15));
                    d = DAY_W'($urandom_range(0, 31));
                end
            endcase
        send_date(d, m, y, add);
    endtask

    initial
    begin
        sb          = new();
        cycle_count = 0;
        calm        = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        start_day   = '0;
        start_month = '0;
        start_year  = '0;
        days_to_add = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // month ends, leap rules, invalid dates, year zero and year wrap
        send_date(5'd1, 4'd1, 14'd1, 15'd0);
        send_date(5'd31, 4'd12, 14'd9999, 15'd1);
        send_date(5'd28, 4'd2, 14'd2000, 15'd1);
        send_date(5'd28, 4'd2, 14'd1900, 15'd1);
        send_date(5'd28, 4'd2, 14'd2024, 15'd1);
        send_date(5'd29, 4'd2, 14'd2023, 15'd5);
        send_date(5'd29, 4'd2, 14'd2024, 15'd365);
        send_date(5'd0, 4'd5, 14'd2020, 15'd10);
        send_date(5'd31, 4'd4, 14'd2021, 15'd10);
        send_date(5'd15, 4'd0, 14'd2021, 15'd10);
        send_date(5'd15, 4'd13, 14'd2021, 15'd10);
        send_date(5'd31, 4'd15, 14'd16383, 15'd32767);
        send_date(5'd29, 4'd2, 14'd0, 15'd0);
        send_date(5'd1, 4'd1, 14'd0, 15'd32767);
        send_date(5'd31, 4'd12, 14'd16383, 15'd32767);
        send_date(5'd31, 4'd12, 14'd16383, 15'd1);
        send_date(5'd1, 4'd1, 14'd16383, 15'd0);
        send_date(5'd31, 4'd1, 14'd2021, 15'd28);
        send_date(5'd30, 4'd11, 14'd2021, 15'd31);
        send_date(5'd1, 4'd3, 14'd2100, 15'd0);
        send_date(5'd15, 4'd6, 14'd5000, 15'd12345);
        send_date(5'd31, 4'd12, 14'd1, 15'd16384);
        drain_results();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = (i >= 120 && i < 220);
            if (i == 200)
                drain_results();
            send_random_date();
        end
        drain_results();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("run covered %0d transfers: %0d valid and %0d invalid start dates",
                 sb.checked, sb.valid_seen, sb.invalid_seen);
        $display("directed leap, month end, year wrap and invalid cases plus random dates");
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[gregorian_add_days_to_date_unit] OK");
        else
            $display("[gregorian_add_days_to_date_unit] ERROR");
        $finish;
    end

endmodule

// File: files.f
src/gadd_pkg.sv
src/gadd_rom.sv
src/gadd_seq.sv
src/gadd_datapath.sv
src/gregorian_add_days_to_date_unit.sv
src/gadd_checker.sv
dv/tb_gregorian_add_days_to_date_unit.sv
